// File: sv/rotated_roi_max_pool_defines.svh
// Assertion macros used by the checker file of the pooling block
`ifndef ROTATED_ROI_MAX_POOL_DEFINES_SVH
`define ROTATED_ROI_MAX_POOL_DEFINES_SVH

// Check a consequence in the cycle after a trigger, outside reset
`define RRMP_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Check a consequence in the cycle after a trigger, reset included
`define RRMP_ASSERT_NEXT_ALL(label, trig, cons) \
  label: assert property (@(posedge clk) (trig) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/rrmp_pkg.sv
// Shared constants and types of the rotated ROI max pooling block
package rrmp_pkg;

  // Beat and configuration widths
  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POOLED_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POOLED_COLS   = 3'd5;

  // Action codes carried in s_tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POOL = 1'b1;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] index_t;

endpackage

// File: sv/rotated_roi_max_pool.sv
// Rotated ROI max pooling over a feature map held in on-chip memory
//
//  channel | dir | beat fields (low bit first)
//  s_*     | in  | tuser: action; tdata: load_address, load_value, batch_index,
//          |     |   roi_x1, roi_y1, roi_x2, roi_y2, rot_cos, rot_sin, bin_row, bin_col
//  m_*     | out | tdata: pooled_value, max_index; tlast: last_channel
//  cfg_*   | in  | write enable, register index, data
//
// A load beat leaves the block ready for the next beat. After a pool beat is
// accepted, setup follows (scaling, sizing, four bin divisions of 17 quotient
// steps, a bin check), then per channel a scan with one memory read per bin
// point and channel, a drain and an emit; an empty bin goes straight to emit.
// Reset is synchronous and clears control state; memory contents stay.
// A stalled output holds the sequencer in its emit step; input waits meanwhile.
module rotated_roi_max_pool #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_BATCHES  = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // load_address, load_value, batch_index, roi_x1, roi_y1, roi_x2, roi_y2,
  // rot_cos, rot_sin, bin_row, bin_col
  input  logic [rrmp_pkg::S_TDATA_W-1:0]   s_tdata,
  // action
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pooled_value, max_index
  output logic [rrmp_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [rrmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rrmp_pkg::*;

  localparam int DEPTH = MAX_BATCHES * MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW = (MAW > 22) ? MAW : 22;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCALE = 4'd1;
  localparam logic [3:0] ST_SIZE  = 4'd2;
  localparam logic [3:0] ST_DIVLD = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_DIVDN = 4'd5;
  localparam logic [3:0] ST_CHK   = 4'd6;
  localparam logic [3:0] ST_SCAN  = 4'd7;
  localparam logic [3:0] ST_DRAIN = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  // Configuration registers
  logic [16:0] coord_scale;
  logic [6:0]  map_height, map_width;
  logic [4:0]  channel_count, pooled_rows, pooled_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_scale   <= 17'd4096;
      map_height    <= 7'd64;
      map_width     <= 7'd64;
      channel_count <= 5'd16;
      pooled_rows   <= 5'd7;
      pooled_cols   <= 5'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COORD_SCALE:   coord_scale   <= cfg_data;
        CFG_MAP_HEIGHT:    map_height    <= cfg_data[6:0];
        CFG_MAP_WIDTH:     map_width     <= cfg_data[6:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_POOLED_ROWS:   pooled_rows   <= cfg_data[4:0];
        CFG_POOLED_COLS:   pooled_cols   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] eff_pr, eff_pc, eff_c;
  assign eff_pr = (pooled_rows == 5'd0) ? 5'd1 : pooled_rows;
  assign eff_pc = (pooled_cols == 5'd0) ? 5'd1 : pooled_cols;
  assign eff_c  = (32'(channel_count) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : channel_count;

  // Input beat fields
  logic [16:0] in_load_address;
  logic [15:0] in_load_value;
  assign in_load_address = s_tdata[16:0];
  assign in_load_value   = s_tdata[32:17];

  logic [3:0]  st;
  logic        accept;
  assign s_tready = (st == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Latched pool request
  logic        batch;
  logic [11:0] x1, y1, x2, y2;
  sample_t     cs, sn;
  logic [3:0]  ph, pw;

  // Setup results
  logic [12:0] sw, sh, ew, eh;
  logic [12:0] rw, rh;
  logic [13:0] mid_w2, mid_h2;
  logic [13:0] hw_prod;
  logic [18:0] base;
  logic [6:0]  hs, he, ws, we;

  // Shared divider
  logic [1:0]  dsel;
  logic [4:0]  dcnt;
  logic [16:0] dnum;
  logic [4:0]  drem;
  logic [4:0]  ddiv;
  logic [5:0]  dtrial;
  logic        dbit;
  assign dtrial = {drem, dnum[16]};
  assign dbit   = (dtrial >= {1'b0, ddiv});

  logic [17:0] dnum_next;
  always_comb begin
    unique case (dsel)
      2'd0: dnum_next = 18'(ph * rh);
      2'd1: dnum_next = 18'(({1'b0, ph} + 5'd1) * rh) + 18'(eff_pr) - 18'd1;
      2'd2: dnum_next = 18'(pw * rw);
      default: dnum_next = 18'(({1'b0, pw} + 5'd1) * rw) + 18'(eff_pc) - 18'd1;
    endcase
  end

  logic [17:0] bnd_sum;
  logic [6:0]  bnd_lim, bnd_clip;
  assign bnd_sum  = 18'(dnum) + 18'((dsel[1]) ? sw : sh);
  assign bnd_lim  = dsel[1] ? map_width : map_height;
  assign bnd_clip = (bnd_sum > 18'(bnd_lim)) ? bnd_lim : bnd_sum[6:0];

  // Scan position and channel
  logic [6:0]  hc, wc;
  logic [4:0]  ch;
  logic        last_pt, bin_empty;
  assign last_pt   = (hc == he - 7'd1) && (wc == we - 7'd1);
  assign bin_empty = (hs >= he) || (ws >= we);

  // Point pipeline
  logic [7:1]         pv;
  logic signed [31:0] pa, pb, pc, pd;
  logic signed [33:0] nw, nh;
  logic [6:0]         wr3, hr3;
  logic [14:0]        rc4;
  logic [20:0]        idx5;
  logic [AW-1:0]      addr6;
  logic [16:0]        idx6, idx7;
  logic               oob6, oob7;
  logic [15:0]        rd7;

  // Running maximum
  logic               found;
  sample_t            best;
  index_t             best_idx;

  logic signed [15:0] dw2, dh2;
  assign dw2 = $signed({8'd0, wc, 1'b0}) - $signed({2'd0, mid_w2});
  assign dh2 = $signed({8'd0, hc, 1'b0}) - $signed({2'd0, mid_h2});

  // Round n / 32768 half away from zero and clamp into [0, lim-1]
  function automatic logic [6:0] round_clamp(input logic signed [33:0] n,
                                             input logic [6:0] lim);
    logic signed [33:0] t, r;
    logic [6:0] lm1;
    lm1 = lim - 7'd1;
    if (n >= 0) begin
      t = n + 34'sd16384;
      r = t >>> 15;
    end else begin
      t = -n + 34'sd16384;
      r = -(t >>> 15);
    end
    if (r < 0) round_clamp = 7'd0;
    else if (r > $signed({27'd0, lm1})) round_clamp = lm1;
    else round_clamp = r[6:0];
  endfunction

  // Pipeline datapath
  always_ff @(posedge clk) begin
    pa <= cs * dw2;
    pb <= sn * dh2;
    pc <= sn * dw2;
    pd <= cs * dh2;
    nw <= 34'(pa) - 34'(pb) + $signed({6'd0, mid_w2, 14'd0});
    nh <= 34'(pc) + 34'(pd) + $signed({6'd0, mid_h2, 14'd0});
    wr3 <= round_clamp(nw, map_width);
    hr3 <= round_clamp(nh, map_height);
    rc4 <= 15'(hr3 * map_width) + 15'(wr3);
    idx5 <= 21'(rc4 * eff_c) + 21'(ch);
    addr6 <= AW'(base) + AW'(idx5);
    idx6 <= idx5[16:0];
    oob6 <= (32'(AW'(base) + AW'(idx5)) >= 32'(DEPTH));
    idx7 <= idx6;
    oob7 <= oob6;
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else pv <= {pv[6:1], (st == ST_SCAN)};
  end

  // Feature memory: one write port for loads, one read port for the scan
  logic [15:0] mem [DEPTH];
  logic [AW-1:0] ld_addr;
  assign ld_addr = AW'(in_load_address);

  always_ff @(posedge clk) begin
    if (accept && s_tuser == ACT_LOAD && 32'(in_load_address) < 32'(DEPTH))
      mem[ld_addr[MAW-1:0]] <= in_load_value;
    rd7 <= mem[addr6[MAW-1:0]];
  end

  sample_t rv7;
  assign rv7 = oob7 ? 16'sd0 : $signed(rd7);

  logic emit_fire;
  assign emit_fire = (st == ST_EMIT) && (!m_tvalid || m_tready);

  // Sequencer and setup arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept && s_tuser == ACT_POOL) begin
            batch <= s_tdata[33];
            x1 <= s_tdata[45:34];
            y1 <= s_tdata[57:46];
            x2 <= s_tdata[69:58];
            y2 <= s_tdata[81:70];
            cs <= s_tdata[97:82];
            sn <= s_tdata[113:98];
            ph <= s_tdata[117:114];
            pw <= s_tdata[121:118];
            st <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          sw <= 13'((30'(x1 * coord_scale) + 30'd32768) >> 16);
          sh <= 13'((30'(y1 * coord_scale) + 30'd32768) >> 16);
          ew <= 13'((30'(x2 * coord_scale) + 30'd32768) >> 16);
          eh <= 13'((30'(y2 * coord_scale) + 30'd32768) >> 16);
          hw_prod <= 14'(map_height * map_width);
          st <= ST_SIZE;
        end
        ST_SIZE: begin
          rw <= (ew >= sw) ? ew - sw + 13'd1 : 13'd1;
          rh <= (eh >= sh) ? eh - sh + 13'd1 : 13'd1;
          mid_w2 <= 14'(sw) + 14'(ew);
          mid_h2 <= 14'(sh) + 14'(eh);
          base <= batch ? 19'(hw_prod * eff_c) : 19'd0;
          dsel <= 2'd0;
          st <= ST_DIVLD;
        end
        ST_DIVLD: begin
          dnum <= dnum_next[16:0];
          drem <= 5'd0;
          ddiv <= dsel[1] ? eff_pc : eff_pr;
          dcnt <= 5'd0;
          st <= ST_DIV;
        end
        ST_DIV: begin
          // One quotient bit per cycle
          drem <= dbit ? 5'(dtrial - {1'b0, ddiv}) : dtrial[4:0];
          dnum <= {dnum[15:0], dbit};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) st <= ST_DIVDN;
        end
        ST_DIVDN: begin
          unique case (dsel)
            2'd0: hs <= bnd_clip;
            2'd1: he <= bnd_clip;
            2'd2: ws <= bnd_clip;
            default: we <= bnd_clip;
          endcase
          dsel <= dsel + 2'd1;
          st <= (dsel == 2'd3) ? ST_CHK : ST_DIVLD;
        end
        ST_CHK: begin
          ch <= 5'd0;
          hc <= hs;
          wc <= ws;
          if (eff_c == 5'd0) st <= ST_IDLE;
          else if (bin_empty) st <= ST_EMIT;
          else st <= ST_SCAN;
        end
        ST_SCAN: begin
          // Walk the clipped bin row by row
          if (wc == we - 7'd1) begin
            wc <= ws;
            hc <= hc + 7'd1;
          end else begin
            wc <= wc + 7'd1;
          end
          if (last_pt) st <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (pv == '0) st <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            hc <= hs;
            wc <= ws;
            ch <= ch + 5'd1;
            if (ch == eff_c - 5'd1) st <= ST_IDLE;
            else if (bin_empty) st <= ST_EMIT;
            else st <= ST_SCAN;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Track the maximum of the current channel
  always_ff @(posedge clk) begin
    if (rst || st == ST_CHK || emit_fire) begin
      found    <= 1'b0;
      best     <= 16'sd0;
      best_idx <= -17'sd1;
    end else if (pv[7] && (!found || rv7 > best)) begin
      found    <= 1'b1;
      best     <= rv7;
      best_idx <= $signed(idx7);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {7'd0, best_idx, best};
      m_tlast <= (ch == eff_c - 5'd1);
    end
  end

endmodule

// File: sv/rrmp_checker.sv
// Port-level checks of the rotated ROI max pooling block and its bind
`include "rotated_roi_max_pool_defines.svh"

module rrmp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rrmp_pkg::M_TDATA_W-1:0]  m_tdata
);
  import rrmp_pkg::*;

  // Output is empty right after reset
  `RRMP_ASSERT_NEXT_ALL(a_reset_empty, rst, !m_tvalid)

  // A stalled result beat holds
  `RRMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A pool beat occupies the block
  `RRMP_ASSERT_NEXT(a_pool_busy, s_tvalid && s_tready && s_tuser == ACT_POOL, !s_tready)

  // After a load beat the block is ready again in the next cycle
  `RRMP_ASSERT_NEXT(a_load_quick, s_tvalid && s_tready && s_tuser == ACT_LOAD, s_tready)

endmodule

bind rotated_roi_max_pool rrmp_checker u_rrmp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
